/* sv/wcec_pkg.sv */
// Shared types, constants and the hash step for the write-coalescing expiry cache.
`timescale 1ns / 1ps

package wcec_pkg;

  localparam int unsigned KeyBits     = 128;
  localparam int unsigned KeyBytes    = KeyBits / 8;
  localparam int unsigned ByteCntBits = $clog2(KeyBytes);
  localparam int unsigned TimeBits    = 32;
  localparam int unsigned TtlBits     = 31;
  localparam int unsigned DlBits      = TimeBits + 1;
  localparam int unsigned DiffBits    = TimeBits + 3;

  localparam logic [31:0] HashBasis = 32'd2166136261;
  localparam logic [31:0] HashPrime = 32'd16777619;

  localparam logic ActCheck  = 1'b0;
  localparam logic ActForget = 1'b1;

  typedef struct packed {
    logic              used;
    logic [63:0]       key_high;
    logic [63:0]       key_low;
    logic [DlBits-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } tbl_cmd_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * HashPrime;
  endfunction

endpackage

/* sv/write_coalescing_expiry_cache_unit.sv */
// Top level of the write-coalescing expiry cache: request control and result register.
// A keyed request goes through ST_HASH, ST_CMP and ST_OUT, a bypassed one only ST_OUT;
// no new request is taken before it leaves ST_OUT. The byte-serial hash unit takes one
// key byte per cycle. The verdict goes via res_wn_q/res_hit_q to the output register.
// After reset the table is swept clear, one entry a cycle, all 2^INDEX_BITS entries
// (4096 by default), with s_axis_tready low; cache_enable resets to 1.
`timescale 1ns / 1ps

module write_coalescing_expiry_cache_unit
  import wcec_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_high [63:0], key_low [127:64], now_seconds [159:128], ttl_seconds [190:160]
  input  logic [191:0] s_axis_tdata,
  // action [0], key_valid [1]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // write_needed [0]
  output logic [7:0]   m_axis_tdata,
  // tag_hit [0]
  output logic         m_axis_tuser
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_HASH = 4'b0010,
    ST_CMP  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic                  enable_q;
  logic                  m_valid_q, m_valid_d;
  logic                  m_wn_q, m_hit_q;
  logic                  action_q;
  logic [TimeBits-1:0]   now_q;
  logic [TtlBits-1:0]    ttl_q;
  logic [DlBits-1:0]     sum_q;
  logic                  res_wn_q, res_wn_d;
  logic                  res_hit_q, res_hit_d;

  logic                  s_accept;
  logic                  bypass;
  logic                  hash_done;
  logic [31:0]           hash;
  logic [KeyBits-1:0]    key;
  tbl_cmd_t              tbl_cmd;
  entry_t                tbl_wdata;
  entry_t                tbl_rdata;
  logic                  clr_busy;
  logic                  hit;
  logic                  ge_sum;
  logic                  ge_half;
  logic                  skip;
  logic [DiffBits-1:0]   diff;
  logic [DiffBits-1:0]   half;
  logic                  out_load;

  assign s_axis_tready = (state_q == ST_IDLE) && !clr_busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign bypass        = !enable_q || !s_axis_tuser[1];

  wcec_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (s_accept && !bypass),
    .key_i   ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
    .done_o  (hash_done),
    .hash_o  (hash),
    .key_o   (key)
  );

  wcec_table #(
    .INDEX_BITS (INDEX_BITS)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (tbl_cmd),
    .addr_i     (hash[INDEX_BITS-1:0]),
    .wdata_i    (tbl_wdata),
    .rdata_o    (tbl_rdata),
    .clr_busy_o (clr_busy)
  );

  assign hit = tbl_rdata.used && (tbl_rdata.key_high == key[KeyBits-1 -: 64])
               && (tbl_rdata.key_low == key[63:0]);
  assign ge_sum  = sum_q >= tbl_rdata.deadline;
  assign diff    = {2'b00, tbl_rdata.deadline} - {3'b000, now_q};
  assign half    = {{(DiffBits - TtlBits + 1){1'b0}}, ttl_q[TtlBits-1:1]};
  assign ge_half = $signed(diff) >= $signed(half);
  assign skip    = hit && ge_sum && ge_half;

  assign out_load = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d    = state_q;
    res_wn_d   = res_wn_q;
    res_hit_d  = res_hit_q;
    tbl_cmd    = '0;
    tbl_wdata  = tbl_rdata;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          if (bypass) begin
            res_wn_d  = (s_axis_tuser[0] == ActCheck);
            res_hit_d = 1'b0;
            state_d   = ST_OUT;
          end else begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          tbl_cmd.rd = 1'b1;
          state_d    = ST_CMP;
        end
      end
      ST_CMP: begin
        res_hit_d = hit;
        if (action_q == ActForget) begin
          res_wn_d       = 1'b0;
          tbl_cmd.wr     = hit;
          tbl_wdata.used = 1'b0;
        end else begin
          res_wn_d   = !skip;
          tbl_cmd.wr = !skip;
          tbl_wdata  = '{used: 1'b1, key_high: key[KeyBits-1 -: 64],
                         key_low: key[63:0], deadline: sum_q};
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
      enable_q  <= 1'b1;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_wn_q  <= res_wn_d;
    res_hit_q <= res_hit_d;
    if (s_accept) begin
      action_q <= s_axis_tuser[0];
      now_q    <= s_axis_tdata[159:128];
      ttl_q    <= s_axis_tdata[190:160];
      sum_q    <= {1'b0, s_axis_tdata[159:128]} + {2'b00, s_axis_tdata[190:160]};
    end
    if (out_load) begin
      m_wn_q  <= res_wn_q;
      m_hit_q <= res_hit_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'd0, m_wn_q};
  assign m_axis_tuser  = m_hit_q;

  a_forget_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT) && (action_q == ActForget) |-> !res_wn_q)
    else $error("forget request reports a write");

  a_write_only_in_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd.wr |-> (state_q == ST_CMP))
    else $error("table written outside compare");

  a_check_miss_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) && (action_q == ActCheck) && !skip |-> tbl_cmd.wr)
    else $error("check miss without table update");

  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !s_accept && (state_q == ST_IDLE))
    else $error("request taken during clearing sweep");

  a_read_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_cmd.rd |=> (state_q == ST_CMP))
    else $error("table read not followed by compare");

endmodule

/* sv/wcec_hash.sv */
// Byte-serial FNV-1a hash unit over a rotating 128-bit key register.
`timescale 1ns / 1ps

module wcec_hash
  import wcec_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [KeyBits-1:0] key_i,
  output logic               done_o,
  output logic [31:0]        hash_o,
  output logic [KeyBits-1:0] key_o
);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [ByteCntBits-1:0] cnt_q, cnt_d;
  logic [31:0]            h_q, h_d;
  logic [KeyBits-1:0]     key_q, key_d;
  logic                   last;

  assign last = (cnt_q == ByteCntBits'(KeyBytes - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    h_d    = h_q;
    key_d  = key_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      h_d    = HashBasis;
      key_d  = key_i;
    end else if (busy_q) begin
      h_d   = fnv_step(h_q, key_q[KeyBits-1 -: 8]);
      key_d = {key_q[KeyBits-9:0], key_q[KeyBits-1 -: 8]};
      cnt_d = cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    key_q <= key_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;
  assign key_o  = key_q;

endmodule

/* sv/wcec_table.sv */
// Direct-mapped entry memory with a clearing sweep after reset.
`timescale 1ns / 1ps

module wcec_table
  import wcec_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tbl_cmd_t              cmd_i,
  input  logic [INDEX_BITS-1:0] addr_i,
  input  entry_t                wdata_i,
  output entry_t                rdata_o,
  output logic                  clr_busy_o
);

  localparam int unsigned Depth = 1 << INDEX_BITS;

  entry_t                mem_q [Depth];
  entry_t                rdata_q;
  logic                  clr_busy_q, clr_busy_d;
  logic [INDEX_BITS-1:0] clr_addr_q, clr_addr_d;
  logic                  wr_en;
  logic [INDEX_BITS-1:0] wr_addr;
  entry_t                wr_data;

  always_comb begin
    clr_busy_d = clr_busy_q;
    clr_addr_d = clr_addr_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + 1'b1;
      if (clr_addr_q == '1) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  assign wr_en   = clr_busy_q | cmd_i.wr;
  assign wr_addr = clr_busy_q ? clr_addr_q : addr_i;
  assign wr_data = clr_busy_q ? entry_t'('0) : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clr_busy_q <= clr_busy_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

/* test/wcec_verdict_checker.sv */
// Checker for the write-coalescing expiry cache: predicts each request's verdict and compares.
`timescale 1ns / 1ps

module wcec_verdict_checker
  import wcec_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [7:0]   m_axis_tdata,
  input  logic         m_axis_tuser,
  output int unsigned  errors_o,
  output int unsigned  outstanding_o
);

  localparam int unsigned Depth = 1 << INDEX_BITS;

  typedef struct packed {
    logic write_needed;
    logic tag_hit;
  } verdict_t;

  logic              enable_q = 1'b1;
  logic              slot_used   [Depth];
  logic [63:0]       slot_key_hi [Depth];
  logic [63:0]       slot_key_lo [Depth];
  logic [DlBits-1:0] slot_dl     [Depth];
  verdict_t          verdicts_due[$];
  verdict_t          seen_v;
  verdict_t          due_v;
  int unsigned       mismatches = 0;

  function automatic logic [INDEX_BITS-1:0] slot_of_key(input logic [63:0] hi,
                                                        input logic [63:0] lo);
    logic [127:0] key;
    logic [31:0]  h;
    int           i;
    key = {hi, lo};
    h   = HashBasis;
    for (i = 0; i < KeyBytes; i++) begin
      h = (h ^ {24'd0, key[127-8*i -: 8]}) * HashPrime;
    end
    return h[INDEX_BITS-1:0];
  endfunction

  function automatic verdict_t predict_verdict(input logic [191:0] data, input logic [1:0] user);
    logic [63:0]           hi;
    logic [63:0]           lo;
    logic [TimeBits-1:0]   now;
    logic [TtlBits-1:0]    ttl;
    logic [INDEX_BITS-1:0] slot;
    logic                  hit;
    logic                  skip;
    longint                n;
    longint                t;
    longint                d;
    verdict_t              v;
    hi  = data[63:0];
    lo  = data[127:64];
    now = data[159:128];
    ttl = data[190:160];
    if (!enable_q || !user[1]) begin
      v.write_needed = (user[0] == ActCheck);
      v.tag_hit      = 1'b0;
      return v;
    end
    slot      = slot_of_key(hi, lo);
    hit       = slot_used[slot] && slot_key_hi[slot] == hi && slot_key_lo[slot] == lo;
    v.tag_hit = hit;
    if (user[0] == ActForget) begin
      if (hit) begin
        slot_used[slot] = 1'b0;
      end
      v.write_needed = 1'b0;
      return v;
    end
    n    = longint'(now);
    t    = longint'(ttl);
    d    = hit ? longint'(slot_dl[slot]) : 64'sd0;
    skip = hit && (n + t >= d) && (d - n >= t / 2);
    if (!skip) begin
      slot_key_hi[slot] = hi;
      slot_key_lo[slot] = lo;
      slot_used[slot]   = 1'b1;
      slot_dl[slot]     = {1'b0, now} + {2'b0, ttl};
    end
    v.write_needed = !skip;
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q = 1'b1;
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
      end
      verdicts_due.delete();
    end else begin
      if (cfg_we_i) begin
        enable_q = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen_v.write_needed = m_axis_tdata[0];
        seen_v.tag_hit      = m_axis_tuser;
        if (verdicts_due.size() == 0) begin
          $error("result beat with no request outstanding");
          mismatches++;
        end else begin
          due_v = verdicts_due.pop_front();
          if (seen_v.write_needed !== due_v.write_needed) begin
            $error("write_needed: expected %0b, got %0b", due_v.write_needed,
                   seen_v.write_needed);
            mismatches++;
          end
          if (seen_v.tag_hit !== due_v.tag_hit) begin
            $error("tag_hit: expected %0b, got %0b", due_v.tag_hit, seen_v.tag_hit);
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        verdicts_due.push_back(predict_verdict(s_axis_tdata, s_axis_tuser));
      end
    end
    errors_o      <= mismatches + verdicts_due.size();
    outstanding_o <= verdicts_due.size();
  end

endmodule

/* test/tb_write_coalescing_expiry_cache_unit.sv */
// Testbench top for the write-coalescing expiry cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_write_coalescing_expiry_cache_unit
  import wcec_pkg::*;
();

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PoolSize   = 32;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         cfg_we_i      = 1'b0;
  logic         cfg_wdata_i   = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic [191:0] s_axis_tdata  = '0;
  logic [1:0]   s_axis_tuser  = '0;
  logic         m_axis_tready = 1'b0;
  logic         s_axis_tready;
  logic         m_axis_tvalid;
  logic [7:0]   m_axis_tdata;
  logic         m_axis_tuser;

  int unsigned  errors;
  int unsigned  outstanding;
  int unsigned  cycle_count = 0;
  int unsigned  beats_taken = 0;
  logic         send_quiet  = 1'b0;
  logic [31:0]  now_base;
  logic [63:0]  pool_hi [PoolSize];
  logic [63:0]  pool_lo [PoolSize];

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  write_coalescing_expiry_cache_unit #(
    .INDEX_BITS(12)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  wcec_verdict_checker #(
    .INDEX_BITS(12)
  ) verdict_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .errors_o      (errors),
    .outstanding_o (outstanding)
  );

  task automatic send_request(input logic action, input logic key_valid, input logic [63:0] hi,
                              input logic [63:0] lo, input logic [31:0] now,
                              input logic [30:0] ttl);
    int unsigned gap;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, ttl, now, lo, hi};
    s_axis_tuser  <= {key_valid, action};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_enable(input logic value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_random_request();
    int unsigned pick;
    int unsigned sel;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [31:0] now;
    logic [30:0] ttl;
    pick = $urandom_range(0, 99);
    sel  = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, PoolSize - 1);
    hi   = pool_hi[sel];
    lo   = pool_lo[sel];
    if ($urandom_range(0, 199) == 0) begin
      now_base = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FF80 : $urandom;
    end
    now_base = now_base + $urandom_range(0, 3);
    now      = now_base;
    ttl      = 31'($urandom_range(8, 200));
    if (pick < 55) begin
      send_request(ActCheck, 1'b1, hi, lo, now, ttl);
    end else if (pick < 67) begin
      send_request(ActForget, 1'b1, hi, lo, now, ttl);
    end else if (pick < 77) begin
      send_request(ActCheck, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                   31'($urandom));
    end else if (pick < 82) begin
      send_request(ActForget, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                   31'($urandom));
    end else if (pick < 88) begin
      send_request($urandom_range(0, 1) ? ActForget : ActCheck, 1'b0, hi, lo, $urandom,
                   31'($urandom));
    end else if (pick < 94) begin
      send_request(ActCheck, 1'b1, hi, lo, $urandom, 31'($urandom));
    end else if (pick < 97) begin
      send_request(ActCheck, 1'b1, hi, lo ^ (64'd1 << $urandom_range(0, 63)), now, ttl);
    end else begin
      pool_hi[sel] = {$urandom, $urandom};
      pool_lo[sel] = {$urandom, $urandom};
      send_request(ActCheck, 1'b1, pool_hi[sel], pool_lo[sel], now, ttl);
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (k % 64 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
      end
      send_random_request();
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    logic        quiet;
    quiet = 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (beats_taken % 64 == 0) begin
        quiet = ($urandom_range(0, 3) == 0);
      end
      stall = quiet ? 0 : $urandom_range(0, 11);
      // hold off long enough for the block to back up into its input
      if (beats_taken == 400) begin
        stall = 600;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      beats_taken++;
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("write_coalescing_expiry_cache_unit: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned k;
    for (k = 0; k < PoolSize; k++) begin
      pool_hi[k] = {$urandom, $urandom};
      pool_lo[k] = {$urandom, $urandom};
    end
    now_base = $urandom;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_enable(1'b1);

    send_request(ActCheck, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd100,
                 31'd50);
    send_request(ActCheck, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd110,
                 31'd50);
    // remaining lifetime under half the ttl
    send_request(ActCheck, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd140,
                 31'd50);
    // time stepped back: now+ttl below the deadline
    send_request(ActCheck, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd100,
                 31'd50);
    send_request(ActCheck, 1'b1, 64'h8123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd100,
                 31'd50);
    send_request(ActForget, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd0,
                 31'd0);
    send_request(ActForget, 1'b1, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd0,
                 31'd0);
    send_request(ActCheck, 1'b0, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'd100,
                 31'd50);
    send_request(ActForget, 1'b0, '1, '1, '1, '1);
    send_request(ActCheck, 1'b1, '1, '1, '1, '1);
    send_request(ActCheck, 1'b1, '1, '1, '1, '1);
    send_request(ActCheck, 1'b1, '0, '0, 32'd0, 31'd1);
    send_request(ActCheck, 1'b1, '0, '0, 32'd0, 31'd1);
    // zero ttl
    send_request(ActCheck, 1'b1, '0, '0, 32'd0, 31'd0);
    send_request(ActCheck, 1'b1, '0, '0, 32'd0, 31'd0);
    send_request(ActForget, 1'b1, '0, '0, '1, '1);
    drain_results();

    write_enable(1'b0);
    send_request(ActCheck, 1'b1, '1, '1, '1, '1);
    send_request(ActForget, 1'b1, '1, '1, '1, '1);
    send_request(ActCheck, 1'b0, '1, '1, '1, '1);
    drain_results();
    // table contents survive the disabled stretch
    write_enable(1'b1);
    send_request(ActCheck, 1'b1, '1, '1, '1, '1);
    send_request(ActForget, 1'b1, '1, '1, '1, '1);

    run_random(700);
    drain_results();
    write_enable(1'b0);
    run_random(120);
    drain_results();
    write_enable(1'b1);
    run_random(1090);
    drain_results();
    repeat (40) @(posedge clk_i);

    if (errors == 0) begin
      $display("write_coalescing_expiry_cache_unit: match");
    end else begin
      $display("write_coalescing_expiry_cache_unit: mismatch");
    end
    $finish;
  end

endmodule
